// ===== hdl/modular_binomial_coefficient_top_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef MODULAR_BINOMIAL_COEFFICIENT_TOP_DEFINES_SVH
`define MODULAR_BINOMIAL_COEFFICIENT_TOP_DEFINES_SVH

`ifndef SYNTH
// Check that a property holds at every rising edge out of reset.
`define MBC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("%m: property check failed");
// Check that a condition never holds at a rising edge out of reset.
`define MBC_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define MBC_ASSERT(lbl, clk_s, rstn_s, prop)
`define MBC_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

// ===== hdl/mbc_pkg.sv =====
`default_nettype none

package mbc_pkg;

  // Field and bus widths
  localparam int N_W    = 63;
  localparam int R_W    = 7;
  localparam int P_W    = 31;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Largest pick count the datapath handles
  localparam logic [R_W-1:0] MAX_R = 7'd64;

  // Register reset values
  localparam logic [P_W-1:0] MODULUS_RESET    = 31'd1000000007;
  localparam logic [R_W-1:0] MAX_CHOOSE_RESET = 7'd50;

  // Register index, taken from paddr word bit
  localparam logic REG_MODULUS    = 1'b0;
  localparam logic REG_MAX_CHOOSE = 1'b1;

  // Serial reducer walks one bit of a 63-bit operand per cycle
  localparam int RED_STEPS = N_W;
  localparam int CNT_W     = $clog2(RED_STEPS);

  // Shared unit operations
  typedef enum logic {
    OP_MUL,
    OP_RED
  } mr_op_t;

  typedef struct packed {
    logic             start;
    mr_op_t           op;
    logic [N_W-1:0]   wide;
    logic [P_W-1:0]   a;
    logic [P_W-1:0]   b;
  } mr_req_t;

  typedef struct packed {
    logic           done;
    logic [P_W-1:0] value;
  } mr_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/mbc_in_if.sv =====
`default_nettype none

interface mbc_in_if;
  logic                      valid;
  logic                      ready;
  logic [mbc_pkg::N_W-1:0]   top_count;
  logic [mbc_pkg::R_W-1:0]   pick_count;

  modport source (output valid, output top_count, output pick_count, input ready);
  modport sink   (input valid, input top_count, input pick_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/mbc_out_if.sv =====
`default_nettype none

interface mbc_out_if;
  logic                      valid;
  logic                      ready;
  logic [mbc_pkg::P_W-1:0]   binomial_value;
  logic                      bad_request;

  modport source (output valid, output binomial_value, output bad_request, input ready);
  modport sink   (input valid, input binomial_value, input bad_request, output ready);
endinterface

`default_nettype wire

// ===== hdl/mbc_cfg.sv =====
`default_nettype none

module mbc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mbc_pkg::DATA_W-1:0]  pwdata,
  output logic      [mbc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [mbc_pkg::P_W-1:0]     modulus,
  output logic      [mbc_pkg::R_W-1:0]     max_choose
);

  logic [mbc_pkg::P_W-1:0] modulus_r;
  logic [mbc_pkg::R_W-1:0] max_choose_r;
  logic                    wr_en;
  logic                    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[mbc_pkg::ADDR_W-1];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= mbc_pkg::MODULUS_RESET;
      max_choose_r <= mbc_pkg::MAX_CHOOSE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        mbc_pkg::REG_MODULUS:    modulus_r    <= pwdata[mbc_pkg::P_W-1:0];
        mbc_pkg::REG_MAX_CHOOSE: max_choose_r <= pwdata[mbc_pkg::R_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_sel)
      mbc_pkg::REG_MODULUS:    prdata = mbc_pkg::DATA_W'(modulus_r);
      mbc_pkg::REG_MAX_CHOOSE: prdata = mbc_pkg::DATA_W'(max_choose_r);
      default:                 prdata = '0;
    endcase
  end

  assign modulus    = modulus_r;
  assign max_choose = max_choose_r;

endmodule

`default_nettype wire

// ===== hdl/mbc_modred.sv =====
`default_nettype none
`include "modular_binomial_coefficient_top_defines.svh"

// Shared modular unit: registers a 31x31 product (or a 63-bit operand),
// then reduces it by the modulus with one restoring step per cycle.
module mbc_modred (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mbc_pkg::mr_req_t         req,
  input  wire logic [mbc_pkg::P_W-1:0]  modulus,
  output mbc_pkg::mr_rsp_t              rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [mbc_pkg::CNT_W-1:0]   cnt_r;
  logic [mbc_pkg::N_W-1:0]     acc_r;
  logic [mbc_pkg::P_W-1:0]     rem_r;

  logic [2*mbc_pkg::P_W-1:0]   prod;
  logic [mbc_pkg::P_W:0]       trial;
  logic [mbc_pkg::P_W:0]       diff;
  logic [mbc_pkg::P_W-1:0]     rem_nxt;
  logic                        load;
  logic                        last_step;

  assign load      = req.start && !busy_r;
  assign last_step = busy_r && (cnt_r == mbc_pkg::CNT_W'(mbc_pkg::RED_STEPS - 1));

  // Form the full product of two residues
  assign prod = {{mbc_pkg::P_W{1'b0}}, req.a} * {{mbc_pkg::P_W{1'b0}}, req.b};

  // Shift in the next operand bit and subtract the modulus when it fits
  assign trial   = {rem_r, acc_r[mbc_pkg::N_W-1]};
  assign diff    = trial - {1'b0, modulus};
  assign rem_nxt = (trial >= {1'b0, modulus}) ? diff[mbc_pkg::P_W-1:0]
                                              : trial[mbc_pkg::P_W-1:0];

  // Sequence the reduction steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + mbc_pkg::CNT_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Hold the operand shift register and partial remainder
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      if (req.op == mbc_pkg::OP_MUL) begin
        acc_r <= mbc_pkg::N_W'(prod);
      end else begin
        acc_r <= req.wide;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      acc_r <= {acc_r[mbc_pkg::N_W-2:0], 1'b0};
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = rem_r;

  `MBC_NEVER(a_no_start_busy, clk, rst_n, req.start && busy_r)
  `MBC_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r))
  `MBC_ASSERT(a_rem_below_mod, clk, rst_n, (busy_r && (modulus >= mbc_pkg::P_W'(2))) |-> (rem_r < modulus))

endmodule

`default_nettype wire

// ===== hdl/mbc_ctrl.sv =====
`default_nettype none
`include "modular_binomial_coefficient_top_defines.svh"

// Sequencer: checks the request; unless rejected or zeroed, it drives the shared
// unit: n mod p, falling product, r!, Fermat exponentiation, final product.
module mbc_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  mbc_in_if.sink                        in_ch,
  mbc_out_if.source                     out_ch,
  input  wire logic [mbc_pkg::P_W-1:0]  modulus,
  input  wire logic [mbc_pkg::R_W-1:0]  max_choose,
  output mbc_pkg::mr_req_t              req,
  input  wire mbc_pkg::mr_rsp_t         rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDN,
    S_NUM,
    S_FACT,
    S_EXP_MUL,
    S_EXP_SQR,
    S_FINAL,
    S_FINISH
  } state_t;

  state_t                     state_r,     state_nxt;
  logic                       pend_r,      pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [mbc_pkg::P_W-1:0]    out_value_r, out_value_nxt;
  logic                       out_bad_r,   out_bad_nxt;
  logic [mbc_pkg::N_W-1:0]    n_r,         n_nxt;
  logic [mbc_pkg::R_W-1:0]    r_r,         r_nxt;
  logic [mbc_pkg::R_W-1:0]    i_r,         i_nxt;
  logic [mbc_pkg::P_W-1:0]    nm_r,        nm_nxt;
  logic [mbc_pkg::P_W-1:0]    num_r,       num_nxt;
  logic [mbc_pkg::P_W-1:0]    fact_r,      fact_nxt;
  logic [mbc_pkg::P_W-1:0]    inv_r,       inv_nxt;
  logic [mbc_pkg::P_W-1:0]    exp_r,       exp_nxt;
  logic [mbc_pkg::P_W-1:0]    res_r,       res_nxt;
  logic                       res_bad_r,   res_bad_nxt;

  logic                       accept;
  logic                       out_free;
  logic                       bad;
  logic                       collapse;
  logic [mbc_pkg::R_W-1:0]    i_inc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign i_inc       = i_r + mbc_pkg::R_W'(1);

  // Reject out-of-range picks; zero everything on a degenerate setup
  assign bad = (in_ch.pick_count > max_choose) ||
               (in_ch.pick_count > mbc_pkg::MAX_R) ||
               (mbc_pkg::N_W'(in_ch.pick_count) > in_ch.top_count);
  assign collapse = (modulus < mbc_pkg::P_W'(2)) ||
                    (mbc_pkg::P_W'(max_choose) >= modulus);

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_bad_nxt   = out_bad_r;
    n_nxt         = n_r;
    r_nxt         = r_r;
    i_nxt         = i_r;
    nm_nxt        = nm_r;
    num_nxt       = num_r;
    fact_nxt      = fact_r;
    inv_nxt       = inv_r;
    exp_nxt       = exp_r;
    res_nxt       = res_r;
    res_bad_nxt   = res_bad_r;

    req       = '0;
    req.op    = mbc_pkg::OP_MUL;
    req.wide  = n_r;

    // Drop the output once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          n_nxt       = in_ch.top_count;
          r_nxt       = in_ch.pick_count;
          i_nxt       = '0;
          num_nxt     = mbc_pkg::P_W'(1);
          fact_nxt    = mbc_pkg::P_W'(1);
          inv_nxt     = mbc_pkg::P_W'(1);
          exp_nxt     = modulus - mbc_pkg::P_W'(2);
          res_nxt     = '0;
          res_bad_nxt = bad;
          if (bad || collapse) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_REDN;
          end
        end
      end

      // Reduce n once; later factors step down from it
      S_REDN: begin
        req.start = !pend_r;
        req.op    = mbc_pkg::OP_RED;
        if (rsp.done) begin
          nm_nxt    = rsp.value;
          state_nxt = (r_r == '0) ? S_EXP_MUL : S_NUM;
        end
      end

      S_NUM: begin
        req.start = !pend_r;
        req.a     = num_r;
        req.b     = nm_r;
        if (rsp.done) begin
          num_nxt   = rsp.value;
          nm_nxt    = (nm_r == '0) ? (modulus - mbc_pkg::P_W'(1))
                                   : (nm_r - mbc_pkg::P_W'(1));
          state_nxt = S_FACT;
        end
      end

      S_FACT: begin
        req.start = !pend_r;
        req.a     = fact_r;
        req.b     = mbc_pkg::P_W'(i_inc);
        if (rsp.done) begin
          fact_nxt  = rsp.value;
          i_nxt     = i_inc;
          state_nxt = (i_inc == r_r) ? S_EXP_MUL : S_NUM;
        end
      end

      // Multiply in the base where the exponent bit is set
      S_EXP_MUL: begin
        if (exp_r[0]) begin
          req.start = !pend_r;
          req.a     = inv_r;
          req.b     = fact_r;
          if (rsp.done) begin
            inv_nxt   = rsp.value;
            state_nxt = S_EXP_SQR;
          end
        end else begin
          state_nxt = S_EXP_SQR;
        end
      end

      // Square the base unless no exponent bits remain
      S_EXP_SQR: begin
        if (exp_r[mbc_pkg::P_W-1:1] == '0) begin
          state_nxt = S_FINAL;
        end else begin
          req.start = !pend_r;
          req.a     = fact_r;
          req.b     = fact_r;
          if (rsp.done) begin
            fact_nxt  = rsp.value;
            exp_nxt   = exp_r >> 1;
            state_nxt = S_EXP_MUL;
          end
        end
      end

      S_FINAL: begin
        req.start = !pend_r;
        req.a     = num_r;
        req.b     = inv_r;
        if (rsp.done) begin
          res_nxt     = rsp.value;
          res_bad_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end
      end

      // Hand the result to the output register when it is free
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Track the operation in flight on the shared unit
    if (req.start) begin
      pend_nxt = 1'b1;
    end else if (rsp.done) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
    n_r         <= n_nxt;
    r_r         <= r_nxt;
    i_r         <= i_nxt;
    nm_r        <= nm_nxt;
    num_r       <= num_nxt;
    fact_r      <= fact_nxt;
    inv_r       <= inv_nxt;
    exp_r       <= exp_nxt;
    res_r       <= res_nxt;
    res_bad_r   <= res_bad_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.binomial_value = out_value_r;
  assign out_ch.bad_request    = out_bad_r;

  `MBC_ASSERT(a_ready_no_pend, clk, rst_n, in_ch.ready |-> !pend_r)
  `MBC_ASSERT(a_done_only_pend, clk, rst_n, rsp.done |-> pend_r)
  `MBC_ASSERT(a_bad_zero, clk, rst_n, (out_valid_r && out_bad_r) |-> (out_value_r == '0))

endmodule

`default_nettype wire

// ===== hdl/modular_binomial_coefficient_top.sv =====
// Channel   Direction  Handshake      Payload
// in_ch     in         valid/ready    top_count[62:0], pick_count[6:0]
// out_ch    out        valid/ready    binomial_value[30:0], bad_request
// cfg       in         APB (psel..)   reg 0 modulus @0x0, reg 1 max_choose @0x4
//
// One modular multiply on the shared unit: a registered 31x31 product, 63 restoring
// reduction steps, then a registered done handoff.
// A valid request runs 2 + 2r + squarings + set bits of p-2 operations on the
// shared unit; a rejected or zeroed request runs none.
// in_ch.ready is high only between requests; a finished result waits in the
// output register while the next request is taken. Reset is synchronous, active low.
`default_nettype none

module modular_binomial_coefficient_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mbc_in_if.sink                           in_ch,
  mbc_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mbc_pkg::DATA_W-1:0]  pwdata,
  output logic      [mbc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic [mbc_pkg::P_W-1:0] modulus;
  logic [mbc_pkg::R_W-1:0] max_choose;
  mbc_pkg::mr_req_t        mr_req;
  mbc_pkg::mr_rsp_t        mr_rsp;

  mbc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .modulus    (modulus),
    .max_choose (max_choose)
  );

  mbc_modred u_modred (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mr_req),
    .modulus (modulus),
    .rsp     (mr_rsp)
  );

  mbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .modulus    (modulus),
    .max_choose (max_choose),
    .req        (mr_req),
    .rsp        (mr_rsp)
  );

endmodule

`default_nettype wire

// ===== dv/mbc_result_checker.sv =====
`timescale 1ns / 1ps

module mbc_result_checker
  import mbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mbc_in_if                 in_mon,
  mbc_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              test_done,
  output int                mismatches,
  output int                pending_results
);

  typedef struct {
    logic [N_W-1:0] n;
    logic [R_W-1:0] r;
    logic [P_W-1:0] value;
    logic           bad;
  } binomial_expect_t;

  binomial_expect_t expected_q[$];
  logic [P_W-1:0]   modulus;
  logic [R_W-1:0]   max_choose;
  logic             leftovers_checked;

  // Compute C(n,r) mod p: falling product times the Fermat inverse of r!
  function automatic binomial_expect_t binomial_residue(input logic [N_W-1:0] n,
                                                        input logic [R_W-1:0] r,
                                                        input logic [P_W-1:0] p,
                                                        input logic [R_W-1:0] maxc);
    binomial_expect_t res;
    longint unsigned  pp, falling, fact, base, acc, e;
    res.n     = n;
    res.r     = r;
    res.value = '0;
    res.bad   = 1'b0;
    // Reject picks above the limit, above the datapath size or above n
    if (r > maxc || r > MAX_R || r > n) begin
      res.bad = 1'b1;
      return res;
    end
    // Degenerate modulus and collapsed table both give zero
    if (p < 2 || maxc >= p) return res;
    pp      = 64'(p);
    falling = 1;
    fact    = 1;
    for (int i = 0; i < int'(r); i++) begin
      falling = (falling * ((64'(n) - 64'(i)) % pp)) % pp;
      fact    = (fact * ((64'(i) + 64'd1) % pp)) % pp;
    end
    // Raise r! to p-2 by square-and-multiply
    acc  = 1;
    base = fact;
    e    = pp - 64'd2;
    while (e != 0) begin
      if ((e & 64'd1) != 0) acc = (acc * base) % pp;
      base = (base * base) % pp;
      e    = e >> 1;
    end
    res.value = P_W'((falling * acc) % pp);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Track configuration, queue predictions, compare result transactions
  always @(posedge clk) begin : monitor
    binomial_expect_t want;
    if (!rst_n) begin
      modulus           = MODULUS_RESET;
      max_choose        = MAX_CHOOSE_RESET;
      leftovers_checked = 1'b0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODULUS) modulus = pwdata[P_W-1:0];
        else max_choose = pwdata[R_W-1:0];
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.insert(expected_q.size(),
                          binomial_residue(in_mon.top_count, in_mon.pick_count,
                                           modulus, max_choose));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d bad=%0b",
                                    out_mon.binomial_value, out_mon.bad_request));
        end else begin
          want = expected_q.pop_front();
          if (out_mon.binomial_value !== want.value)
            report_mismatch($sformatf("n=%0d r=%0d binomial_value=%0d, expected %0d",
                                      want.n, want.r, out_mon.binomial_value, want.value));
          if (out_mon.bad_request !== want.bad)
            report_mismatch($sformatf("n=%0d r=%0d bad_request=%0b, expected %0b",
                                      want.n, want.r, out_mon.bad_request, want.bad));
        end
      end
      // Flag results still owed once the run is over
      if (test_done && !leftovers_checked) begin
        if (expected_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        leftovers_checked = 1'b1;
      end
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== dv/modular_binomial_coefficient_top_tb.sv =====
`timescale 1ns / 1ps

module modular_binomial_coefficient_top_tb;
  import mbc_pkg::*;

  typedef enum logic [2:0] {
    CFG_PRIME,
    CFG_COMPOSITE,
    CFG_LARGE,
    CFG_COLLAPSE,
    CFG_DEGENERATE
  } cfg_kind_e;

  localparam int RANDOM_PHASES   = 11;
  localparam int ITEMS_PER_PHASE = 51;
  localparam int STEADY_PHASE    = 0;
  localparam int PRESSURE_PHASE  = 2;
  localparam int IDLE_PCT        = 21;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int WATCHDOG_LIMIT  = 100000;
  localparam int TAIL_CYCLES     = 200;

  localparam logic [N_W-1:0] N_MAX      = '1;
  localparam logic [P_W-1:0] P_MERSENNE = '1;
  localparam logic [N_W-1:0] N_AT_P     = N_W'(MODULUS_RESET);

  localparam int unsigned SMALL_PRIMES [12] = '{2, 3, 5, 7, 11, 13, 17, 31, 61, 97, 127, 251};
  localparam cfg_kind_e PHASE_PLAN [RANDOM_PHASES] = '{
    CFG_PRIME, CFG_PRIME, CFG_COLLAPSE, CFG_LARGE, CFG_COMPOSITE, CFG_DEGENERATE,
    CFG_PRIME, CFG_COMPOSITE, CFG_PRIME, CFG_COLLAPSE, CFG_PRIME
  };

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              steady;
  logic              test_done;
  int                mismatches;
  int                pending_results;
  int                hold_off_asked;
  int                hold_off_served;

  mbc_in_if  in_ch();
  mbc_out_if out_ch();

  modular_binomial_coefficient_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mbc_result_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .test_done       (test_done),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Write one register through a setup and an access cycle
  task automatic write_reg(input logic reg_index, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [P_W-1:0] p, input logic [R_W-1:0] maxc);
    write_reg(REG_MODULUS, DATA_W'(p));
    write_reg(REG_MAX_CHOOSE, DATA_W'(maxc));
  endtask

  // Offer one request transaction, idling at random, and hold until accepted
  task automatic offer_request(input logic [N_W-1:0] n, input logic [R_W-1:0] r);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.top_count  <= n;
    in_ch.pick_count <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    out_ch.ready    = 1'b0;
    hold_off_served = 0;
    forever begin
      @(negedge clk);
      if (hold_off_asked != hold_off_served) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_served++;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("** modular_binomial_coefficient_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [P_W-1:0] p;
    logic [R_W-1:0] maxc;
    logic [R_W-1:0] r;
    logic [N_W-1:0] n;
    int unsigned    cap;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.top_count  = '0;
    in_ch.pick_count = '0;
    steady           = 1'b0;
    test_done        = 1'b0;
    hold_off_asked   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty pick, largest legal pick, rejections, n at p
    offer_request('0, '0);
    offer_request(N_MAX, '0);
    offer_request(N_MAX, R_W'(50));
    offer_request(N_MAX, R_W'(51));
    offer_request(N_W'(3), R_W'(4));
    offer_request(N_W'(7), R_W'(7));
    offer_request(N_AT_P, R_W'(1));
    offer_request(N_AT_P + N_W'(3), R_W'(5));
    offer_request(N_W'(64'd123456789012345678), R_W'(17));
    offer_request(N_W'(64), R_W'(50));
    settle();

    // Largest modulus and largest pick limit
    set_config(P_MERSENNE, MAX_R);
    offer_request(N_MAX, MAX_R);
    offer_request(N_W'(64), MAX_R);
    offer_request(N_W'(63), MAX_R);
    offer_request(N_W'(64'h2AAA_AAAA_AAAA_AAAA), R_W'(33));
    settle();

    // Smallest prime: the Fermat exponent is zero
    set_config(P_W'(2), R_W'(1));
    offer_request(N_MAX, R_W'(1));
    offer_request('0, '0);
    offer_request(N_W'(5), R_W'(2));
    settle();
    set_config(P_W'(2), '0);
    offer_request(N_W'(10), '0);
    settle();

    // Table collapse: pick limit not below modulus
    set_config(P_W'(61), MAX_R);
    offer_request(N_W'(100), R_W'(10));
    offer_request(N_W'(5), R_W'(10));
    settle();

    // Degenerate modulus values
    set_config('0, '0);
    offer_request(N_W'(9), '0);
    offer_request(N_W'(9), R_W'(1));
    settle();
    set_config(P_W'(1), R_W'(3));
    offer_request(N_W'(9), R_W'(2));
    settle();

    // Composite modulus
    set_config(P_W'(1000), R_W'(10));
    offer_request(N_W'(123456), R_W'(6));
    offer_request(N_MAX, R_W'(10));
    settle();

    // Random phases, each with its own settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (PHASE_PLAN[ph])
        CFG_PRIME: begin
          p    = P_W'(SMALL_PRIMES[$urandom_range(11)]);
          maxc = R_W'($urandom_range((p - 1 < 12) ? int'(p) - 1 : 12));
        end
        CFG_COMPOSITE: begin
          p    = P_W'($urandom_range(300, 4));
          maxc = R_W'($urandom_range(12));
        end
        CFG_LARGE: begin
          p    = {1'b1, 30'($urandom)};
          maxc = R_W'($urandom_range(10));
        end
        CFG_COLLAPSE: begin
          p    = P_W'($urandom_range(64, 2));
          maxc = R_W'($urandom_range(64, int'(p)));
        end
        default: begin
          p    = P_W'($urandom_range(1));
          maxc = R_W'($urandom_range(64));
        end
      endcase
      set_config(p, maxc);
      steady = (ph == STEADY_PHASE);
      // Stall the result side long enough for the block to back up
      if (ph == PRESSURE_PHASE) hold_off_asked++;
      cap = (maxc < 6) ? int'(maxc) : 6;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        case ($urandom_range(9))
          6:       r = maxc;
          7:       r = (maxc < MAX_R) ? R_W'(maxc + 1) : MAX_R;
          8:       r = R_W'($urandom_range(64));
          default: r = R_W'($urandom_range(cap));
        endcase
        case ($urandom_range(9))
          0, 1:    n = N_W'($urandom_range(70));
          2, 3:    n = N_W'(64'(p) * 64'($urandom_range(1000000)) + 64'($urandom_range(8)));
          4:       n = N_MAX - N_W'($urandom_range(100));
          default: n = N_W'({$urandom, $urandom});
        endcase
        offer_request(n, r);
      end
      settle();
    end
    steady = 1'b0;

    // Let the block go quiet, then collect any leftovers
    repeat (TAIL_CYCLES) @(negedge clk);
    test_done <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (mismatches == 0)
      $display("** modular_binomial_coefficient_top: PASSED **");
    else
      $display("** modular_binomial_coefficient_top: FAILED **");
    $finish;
  end

endmodule
